// File: rtl/core/jse_pkg.sv
// Package with the escape table and the escape function of the JSON string escaper.
`default_nettype none

package jse_pkg;

  // Character codes used by the escape rules.
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharLetterN   = 8'h6E;
  localparam logic [7:0] CharLetterR   = 8'h72;
  localparam logic [7:0] CharLetterT   = 8'h74;
  localparam logic [7:0] CharLetterB   = 8'h62;
  localparam logic [7:0] CharLetterF   = 8'h66;
  localparam logic [7:0] CharLetterU   = 8'h75;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharNewline   = 8'h0A;
  localparam logic [7:0] CharReturn    = 8'h0D;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharBackspace = 8'h08;
  localparam logic [7:0] CharFormFeed  = 8'h0C;
  localparam logic [7:0] CtrlLimit     = 8'h20;
  localparam logic [7:0] AsciiMax      = 8'h7F;

  // Longest escape sequence in bytes.
  localparam int unsigned MaxEscLen = 6;
  localparam int unsigned EscLenW   = $clog2(MaxEscLen + 1);

  // Lower-case hex digits.
  localparam logic [15:0][7:0] HexDigits = {
    8'h66, 8'h65, 8'h64, 8'h63, 8'h62, 8'h61, 8'h39, 8'h38,
    8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
  };

  // Escape of one byte: length (zero when refused) and bytes, first byte at index 0.
  typedef struct packed {
    logic [EscLenW-1:0]           len;
    logic [MaxEscLen-1:0][7:0]    seq;
  } esc_t;

  function automatic esc_t escape_byte(input logic [7:0] c);
    esc_t r;
    logic [7:0] short_char;
    r = '0;
    short_char = '0;
    unique case (c)
      CharQuote:     short_char = CharQuote;
      CharBackslash: short_char = CharBackslash;
      CharNewline:   short_char = CharLetterN;
      CharReturn:    short_char = CharLetterR;
      CharTab:       short_char = CharLetterT;
      CharBackspace: short_char = CharLetterB;
      CharFormFeed:  short_char = CharLetterF;
      default:       short_char = '0;
    endcase
    priority if (short_char != '0) begin
      r.len    = EscLenW'(2);
      r.seq[0] = CharBackslash;
      r.seq[1] = short_char;
    end else if (c < CtrlLimit) begin
      r.len    = EscLenW'(MaxEscLen);
      r.seq[0] = CharBackslash;
      r.seq[1] = CharLetterU;
      r.seq[2] = CharZero;
      r.seq[3] = CharZero;
      r.seq[4] = HexDigits[c[7:4]];
      r.seq[5] = HexDigits[c[3:0]];
    end else if (c > AsciiMax) begin
      r.len = '0;
    end else begin
      r.len    = EscLenW'(1);
      r.seq[0] = c;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/json_string_escaper_core.sv
// Top level of the JSON string escaper: byte escaping, room check and beat sequencing.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+------------------------------------------
//   in      | input     | in_valid_i/in_stall_o | data_byte_i, has_byte_i, end_of_string_i
//   out     | output    | out_valid_o/out_stall_i | out_char_o, is_final_o, failed_o,
//           |           |                       | total_length_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (buffer_room)
//
// An input beat is escaped and checked against the room in the cycle it is accepted and
// loaded into a sequence buffer; output beats leave it one per cycle, while the output is
// not stalled, through an output register. An item makes 0 to 7 beats.
// Reset clears the counters, the failure flag and both buffers; buffer_room returns to 65535.
// A stall on the output holds the output register; the input stalls only when the buffer
// still holds more than the beat about to leave.
`default_nettype none

module json_string_escaper_core
  import jse_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        has_byte_i,
  input  wire logic        end_of_string_i,
  // Output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_char_o,
  output logic             is_final_o,
  output logic             failed_o,
  output logic [15:0]      total_length_o,
  // Configuration channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  // Configuration and per-string state.
  logic [15:0] room_q;
  logic [15:0] wc_q, wc_d;
  logic        fail_q, fail_d;

  // Sequence buffer: escape bytes still to send, then an optional final beat.
  logic [MaxEscLen-1:0][7:0] seq_q, seq_d;
  logic [EscLenW-1:0]        cnt_q, cnt_d;
  logic                      fin_q, fin_d;
  logic                      fin_fail_q, fin_fail_d;
  logic [15:0]               fin_len_q, fin_len_d;

  // Output register.
  logic        out_valid_q;
  logic [7:0]  out_char_q;
  logic        out_final_q;
  logic        out_failed_q;
  logic [15:0] out_len_q;

  logic        buf_empty, buf_one, out_move, pop, in_acc;
  esc_t        esc;
  logic [16:0] need;
  logic        take, fits;
  logic [15:0] wc_new;
  logic        fail_new;

  assign cfg_ready_o = 1'b1;

  // Buffer occupancy and handshake.
  assign buf_empty  = (cnt_q == '0) && !fin_q;
  assign buf_one    = ((cnt_q == EscLenW'(1)) && !fin_q) || ((cnt_q == '0) && fin_q);
  assign out_move   = !out_valid_q || !out_stall_i;
  assign pop        = out_move && !buf_empty;
  assign in_stall_o = !(buf_empty || (buf_one && out_move));
  assign in_acc     = in_valid_i && !in_stall_o;

  // Escape the byte and check that it and the terminator still fit.
  assign esc      = escape_byte(data_byte_i);
  assign need     = {1'b0, wc_q} + 17'(esc.len) + 17'd1;
  assign take     = has_byte_i && !fail_q;
  assign fits     = (esc.len != '0) && (need <= {1'b0, room_q});
  assign wc_new   = (take && fits) ? wc_q + 16'(esc.len) : wc_q;
  assign fail_new = fail_q || (take && !fits);

  // Next state of the string counters and the sequence buffer.
  always_comb begin
    wc_d       = wc_q;
    fail_d     = fail_q;
    seq_d      = seq_q;
    cnt_d      = cnt_q;
    fin_d      = fin_q;
    fin_fail_d = fin_fail_q;
    fin_len_d  = fin_len_q;
    if (pop) begin
      if (cnt_q != '0) begin
        seq_d = {8'h00, seq_q[MaxEscLen-1:1]};
        cnt_d = cnt_q - EscLenW'(1);
      end else begin
        fin_d = 1'b0;
      end
    end
    if (in_acc) begin
      seq_d      = esc.seq;
      cnt_d      = (take && fits) ? esc.len : '0;
      fin_d      = end_of_string_i;
      fin_fail_d = fail_new || (room_q == '0);
      fin_len_d  = wc_new;
      if (end_of_string_i) begin
        wc_d   = '0;
        fail_d = 1'b0;
      end else begin
        wc_d   = wc_new;
        fail_d = fail_new;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_q      <= 16'hFFFF;
      wc_q        <= '0;
      fail_q      <= 1'b0;
      cnt_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        room_q <= cfg_data_i;
      end
      wc_q   <= wc_d;
      fail_q <= fail_d;
      cnt_q  <= cnt_d;
      fin_q  <= fin_d;
      if (out_move) begin
        out_valid_q <= !buf_empty;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    seq_q      <= seq_d;
    fin_fail_q <= fin_fail_d;
    fin_len_q  <= fin_len_d;
    if (out_move) begin
      if (cnt_q != '0) begin
        out_char_q   <= seq_q[0];
        out_final_q  <= 1'b0;
        out_failed_q <= 1'b0;
        out_len_q    <= '0;
      end else begin
        out_char_q   <= 8'h00;
        out_final_q  <= 1'b1;
        out_failed_q <= fin_fail_q;
        out_len_q    <= fin_len_q;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_char_o     = out_char_q;
  assign is_final_o     = out_final_q;
  assign failed_o       = out_failed_q;
  assign total_length_o = out_len_q;

endmodule

`default_nettype wire

// File: rtl/core/jse_checker.sv
// Port-level checker for the JSON string escaper and its bind statement.
`default_nettype none

module jse_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  out_char_o,
  input wire logic        is_final_o,
  input wire logic        failed_o,
  input wire logic [15:0] total_length_o
);

  // A stalled output beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // The terminator beat carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_final_o |-> out_char_o == 8'h00)
    else $error("terminator beat with nonzero byte");

  // Escape beats carry no failure flag and no length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_final_o |-> !failed_o && total_length_o == 16'h0000)
    else $error("status fields set on an escape beat");

  // An escape beat never carries a zero byte, since every escape byte is 20h or above.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_final_o |-> out_char_o != 8'h00)
    else $error("zero byte on an escape beat");

endmodule

bind json_string_escaper_core jse_checker u_jse_checker (.*);

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench of the JSON string escaper with a queue-fed driver and a checking monitor.
module tb_top;
  import jse_pkg::*;

  localparam int unsigned ResetCycles   = 6;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ShownErrors   = 10;
  localparam logic [15:0] RoomMax       = 16'hFFFF;

  // One input beat as the driver presents it.
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eos;
  } raw_item_t;

  // One output beat as the block should produce it.
  typedef struct packed {
    logic [7:0]  ch;
    logic        fin;
    logic        fl;
    logic [15:0] len;
  } escaped_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        has_byte_i;
  logic        end_of_string_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_char_o;
  logic        is_final_o;
  logic        failed_o;
  logic [15:0] total_length_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  // Stimulus and expectation stores.
  raw_item_t     raw_items[$];
  escaped_beat_t escaped_beats[$];

  // Shadow copy of the block state and its register.
  int unsigned room;
  int unsigned bytes_written;
  logic        string_failed;

  // Flow control of the testbench itself.
  logic        in_beat_taken;
  logic        idle_on;
  logic        hold_request;
  int unsigned src_gap;
  int unsigned sink_gap;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned errors;

  json_string_escaper_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .has_byte_i      (has_byte_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_char_o      (out_char_o),
    .is_final_o      (is_final_o),
    .failed_o        (failed_o),
    .total_length_o  (total_length_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Lower-case hex digit of a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CharZero + 8'(nib);
    end
    return 8'h57 + 8'(nib);
  endfunction

  // Builds the JSON escape of one byte; the length is zero for a refused byte.
  function automatic int unsigned escape_char(input logic [7:0] c,
                                              output logic [5:0][7:0] seq);
    logic [7:0] short_code;
    seq = '0;
    case (c)
      CharQuote:     short_code = CharQuote;
      CharBackslash: short_code = CharBackslash;
      CharNewline:   short_code = CharLetterN;
      CharReturn:    short_code = CharLetterR;
      CharTab:       short_code = CharLetterT;
      CharBackspace: short_code = CharLetterB;
      CharFormFeed:  short_code = CharLetterF;
      default:       short_code = 8'h00;
    endcase
    if (short_code != 8'h00) begin
      seq[0] = CharBackslash;
      seq[1] = short_code;
      return 2;
    end
    if (c < CtrlLimit) begin
      seq[0] = CharBackslash;
      seq[1] = CharLetterU;
      seq[2] = CharZero;
      seq[3] = CharZero;
      seq[4] = hex_digit(c[7:4]);
      seq[5] = hex_digit(c[3:0]);
      return 6;
    end
    if (c > AsciiMax) begin
      return 0;
    end
    seq[0] = c;
    return 1;
  endfunction

  // Escapes one accepted item, checks the room and queues the beats it must produce.
  function automatic void escape_and_count(input logic [7:0] c, input logic has,
                                           input logic eos);
    logic [5:0][7:0] seq;
    int unsigned     n;
    escaped_beat_t   beat;
    if (has && !string_failed) begin
      n = escape_char(c, seq);
      if (n == 0 || bytes_written + n + 1 > room) begin
        string_failed = 1'b1;
      end else begin
        for (int i = 0; i < n; i++) begin
          beat = '{ch: seq[i], fin: 1'b0, fl: 1'b0, len: 16'd0};
          escaped_beats.push_back(beat);
        end
        bytes_written += n;
      end
    end
    if (eos) begin
      beat = '{ch: 8'h00, fin: 1'b1, fl: string_failed || room == 0,
               len: 16'(bytes_written)};
      escaped_beats.push_back(beat);
      bytes_written = 0;
      string_failed = 1'b0;
    end
  endfunction

  // Counts a failure and shows only the first few.
  task automatic note_error(input string msg);
    errors++;
    if (errors <= ShownErrors) begin
      $display("%s", msg);
    end
  endtask

  // Random byte weighted toward text, with escapes, controls and refused bytes mixed in.
  function automatic logic [7:0] rand_text_byte();
    logic [7:0] specials[7];
    int unsigned pick;
    specials = '{CharQuote, CharBackslash, CharNewline, CharReturn, CharTab,
                 CharBackspace, CharFormFeed};
    pick = $urandom_range(0, 19);
    if (pick == 0) return 8'(8'h80 + $urandom_range(0, 127));
    if (pick <= 3) return specials[$urandom_range(0, 6)];
    if (pick <= 5) return 8'($urandom_range(0, 31));
    if (pick == 6) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(32, 127));
  endfunction

  // Queues whole random strings until about the given number of counted items.
  task automatic queue_random_strings(input int unsigned count, input int unsigned max_len);
    int unsigned added;
    int unsigned len;
    logic        eos_on_byte;
    added = 0;
    while (added < count) begin
      len = $urandom_range(0, max_len);
      eos_on_byte = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          raw_items.push_back('{data: 8'($urandom), has: 1'b0, eos: 1'b0});
        end
        raw_items.push_back('{data: rand_text_byte(), has: 1'b1,
                              eos: (i == len - 1) && eos_on_byte});
        added++;
      end
      if (len == 0 || !eos_on_byte) begin
        raw_items.push_back('{data: 8'($urandom), has: 1'b0, eos: 1'b1});
        added++;
      end
    end
  endtask

  // Queues a directed string of bytes, optionally closed on its last byte.
  task automatic queue_bytes(input logic [7:0] bytes[$], input logic close);
    for (int i = 0; i < bytes.size(); i++) begin
      raw_items.push_back('{data: bytes[i], has: 1'b1,
                            eos: close && (i == bytes.size() - 1)});
    end
  endtask

  // Writes the room register; only called while the block is idle.
  task automatic write_room(input logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    room = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every item is taken and every beat has arrived, then lets the block settle.
  task automatic wait_idle();
    while (raw_items.size() != 0 || in_valid_i || escaped_beats.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Input driver: presents queued items at the falling edge, with random gaps.
  always @(negedge clk_i) begin
    raw_item_t nxt;
    if (rst_ni && (!in_valid_i || in_beat_taken)) begin
      if (src_gap != 0) begin
        src_gap    <= src_gap - 1;
        in_valid_i <= 1'b0;
      end else if (raw_items.size() != 0 && idle_on && $urandom_range(0, 5) == 0) begin
        src_gap    <= $urandom_range(0, 14);
        in_valid_i <= 1'b0;
      end else if (raw_items.size() != 0) begin
        nxt = raw_items.pop_front();
        in_valid_i      <= 1'b1;
        data_byte_i     <= nxt.data;
        has_byte_i      <= nxt.has;
        end_of_string_i <= nxt.eos;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output receiver: random stall bursts and, on request, one long hold-off.
  always @(negedge clk_i) begin
    logic stall_now;
    stall_now = 1'b0;
    if (hold_request) begin
      hold_left    = LongHold;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      stall_now = 1'b1;
    end else if (sink_gap != 0) begin
      sink_gap--;
      stall_now = 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      sink_gap  = $urandom_range(0, 14);
      stall_now = 1'b1;
    end
    out_stall_i <= stall_now;
  end

  // Monitor: predicts on accepted inputs, checks accepted outputs, and runs the watchdog.
  always @(posedge clk_i) begin
    escaped_beat_t got;
    escaped_beat_t want;
    if (rst_ni) begin
      in_beat_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        escape_and_count(data_byte_i, has_byte_i, end_of_string_i);
      end
      if (out_valid_o && !out_stall_i) begin
        got = {out_char_o, is_final_o, failed_o, total_length_o};
        if (escaped_beats.size() == 0) begin
          note_error($sformatf("unexpected beat: char %02h final %0b failed %0b length %0d",
                               got.ch, got.fin, got.fl, got.len));
        end else begin
          want = escaped_beats.pop_front();
          if (got !== want) begin
            note_error($sformatf({"mismatch: expected char %02h final %0b failed %0b ",
                                  "length %0d, got char %02h final %0b failed %0b length %0d"},
                                 want.ch, want.fin, want.fl, want.len,
                                 got.ch, got.fin, got.fl, got.len));
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Test sequence: reset, directed strings, pressure, then random phases.
  initial begin
    logic [7:0] text[$];
    logic [15:0] next_room;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = 8'h00;
    has_byte_i      = 1'b0;
    end_of_string_i = 1'b0;
    out_stall_i     = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = 16'h0000;
    in_beat_taken   = 1'b0;
    idle_on         = 1'b1;
    hold_request    = 1'b0;
    src_gap         = 0;
    sink_gap        = 0;
    hold_left       = 0;
    quiet_cycles    = 0;
    errors          = 0;
    room            = RoomMax;
    bytes_written   = 0;
    string_failed   = 1'b0;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All short escapes, both control extremes, printable extremes.
    write_room(RoomMax);
    text = '{CharQuote, CharBackslash, CharNewline, CharReturn, CharTab, CharBackspace,
             CharFormFeed, 8'h00, 8'h1F, 8'h20, 8'h7F};
    queue_bytes(text, 1'b1);
    // An empty item makes nothing; a refused byte suppresses the rest of its string.
    raw_items.push_back('{data: 8'hAA, has: 1'b0, eos: 1'b0});
    text = '{8'h41, 8'h80, 8'h42, 8'hFF};
    queue_bytes(text, 1'b1);
    // An empty string.
    raw_items.push_back('{data: 8'h55, has: 1'b0, eos: 1'b1});
    wait_idle();

    // Room zero always fails, even for an empty string.
    write_room(16'd0);
    text = '{8'h61};
    queue_bytes(text, 1'b1);
    raw_items.push_back('{data: 8'h00, has: 1'b0, eos: 1'b1});
    wait_idle();

    // Room three: a short escape just fits; later a byte that does not fit latches failure.
    write_room(16'd3);
    text = '{CharNewline};
    queue_bytes(text, 1'b1);
    text = '{8'h61, 8'h62, 8'h63};
    queue_bytes(text, 1'b1);
    wait_idle();

    // Room changed in the middle of a string.
    write_room(RoomMax);
    text = '{8'h78, 8'h79};
    queue_bytes(text, 1'b0);
    wait_idle();
    write_room(16'd4);
    text = '{8'h7A, CharQuote, 8'h71};
    queue_bytes(text, 1'b1);
    wait_idle();

    // Long receiver hold-off while the sender keeps offering items.
    write_room(RoomMax);
    hold_request = 1'b1;
    queue_random_strings(10, 10);
    wait_idle();

    // Random phases over several room settings.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       next_room = 16'($urandom_range(0, 24));
        1:       next_room = 16'($urandom_range(0, 65535));
        2:       next_room = 16'($urandom_range(2, 12));
        3:       next_room = 16'd1;
        default: next_room = 16'($urandom_range(8, 64));
      endcase
      write_room(next_room);
      idle_on = (p != 2);
      queue_random_strings(6, 12);
      wait_idle();
    end

    // Closing phase at full rate on both sides.
    idle_on = 1'b0;
    write_room(RoomMax);
    queue_random_strings(8, 12);
    wait_idle();

    if (escaped_beats.size() != 0) begin
      note_error($sformatf("%0d expected beats never arrived", escaped_beats.size()));
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
